// ===== rtl/pwc_pkg.sv =====
`default_nettype none

package pwc_pkg;

    // operation codes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // register write targets
    localparam logic [2:0] REG_DUTY   = 3'd0;
    localparam logic [2:0] REG_SWEEP  = 3'd1;
    localparam logic [2:0] REG_LOW    = 3'd2;
    localparam logic [2:0] REG_HIGH   = 3'd3;
    localparam logic [2:0] REG_ENABLE = 3'd4;

    localparam logic [10:0] MIN_PERIOD = 11'h008;

    typedef struct packed {
        logic       operation;
        logic [2:0] reg_index;
        logic [7:0] write_data;
        logic       quarter_clock;
        logic       half_clock;
    } t_item;

    typedef struct packed {
        logic signed [6:0] sample_out;
        logic              length_nonzero;
    } t_result;

    function automatic logic [7:0] f_length_load(input logic [4:0] idx);
        logic [7:0] v;
        case (idx)
            5'd0:  v = 8'h0A;  5'd1:  v = 8'hFE;  5'd2:  v = 8'h14;  5'd3:  v = 8'h02;
            5'd4:  v = 8'h28;  5'd5:  v = 8'h04;  5'd6:  v = 8'h50;  5'd7:  v = 8'h06;
            5'd8:  v = 8'hA0;  5'd9:  v = 8'h08;  5'd10: v = 8'h3C;  5'd11: v = 8'h0A;
            5'd12: v = 8'h0E;  5'd13: v = 8'h0C;  5'd14: v = 8'h1A;  5'd15: v = 8'h0E;
            5'd16: v = 8'h0C;  5'd17: v = 8'h10;  5'd18: v = 8'h18;  5'd19: v = 8'h12;
            5'd20: v = 8'h30;  5'd21: v = 8'h14;  5'd22: v = 8'h60;  5'd23: v = 8'h16;
            5'd24: v = 8'hC0;  5'd25: v = 8'h18;  5'd26: v = 8'h48;  5'd27: v = 8'h1A;
            5'd28: v = 8'h10;  5'd29: v = 8'h1C;  5'd30: v = 8'h20;  5'd31: v = 8'h1E;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    // high part of the duty wave
    function automatic logic f_duty_high(input logic [1:0] mode, input logic [2:0] step);
        logic h;
        case (mode)
            2'd0:    h = (step == 3'd7);
            2'd1:    h = (step >= 3'd6);
            2'd2:    h = (step >= 3'd4);
            default: h = (step <= 3'd5);
        endcase
        return h;
    endfunction

    // period in range and the add-mode sweep target stays below 0x800
    function automatic logic f_period_ok(input logic [10:0] period, input logic [2:0] shift,
                                         input logic negate);
        logic [11:0] target;
        target = {1'b0, period} + {1'b0, period >> shift};
        return (period >= MIN_PERIOD) && (negate || !target[11]);
    endfunction

    function automatic logic signed [6:0] f_level(input logic [1:0] mode, input logic [2:0] step,
                                                  input logic [3:0] vol);
        logic signed [6:0] mag;
        mag = {1'b0, vol, 2'b00};
        return f_duty_high(mode, step) ? mag : -mag;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/pwc_channel_state.sv =====
`default_nettype none

module pwc_channel_state
    import pwc_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_step,
    input  wire t_item   i_item,
    output t_result      o_result
);

    logic [10:0] r_period, n_period;
    logic [11:0] r_timer, n_timer;
    logic [2:0]  r_duty_step, n_duty_step;
    logic [1:0]  r_duty_mode, n_duty_mode;
    logic [3:0]  r_volume, n_volume;
    logic        r_const_vol, n_const_vol;
    logic        r_halt, n_halt;
    logic        r_pend_halt, n_pend_halt;
    logic [3:0]  r_decay, n_decay;
    logic [3:0]  r_env_div, n_env_div;
    logic        r_env_start, n_env_start;
    logic [2:0]  r_sw_shift, n_sw_shift;
    logic        r_sw_negate, n_sw_negate;
    logic [2:0]  r_sw_period, n_sw_period;
    logic        r_sw_enable, n_sw_enable;
    logic [2:0]  r_sw_div, n_sw_div;
    logic        r_sw_reload, n_sw_reload;
    logic [7:0]  r_length, n_length;
    logic [7:0]  r_pend_len, n_pend_len;
    logic [7:0]  r_len_snap, n_len_snap;
    logic signed [6:0] r_held, n_held;

    logic [10:0] sw_delta;
    logic [7:0]  wd;

    always_comb begin
        n_period    = r_period;
        n_timer     = r_timer;
        n_duty_step = r_duty_step;
        n_duty_mode = r_duty_mode;
        n_volume    = r_volume;
        n_const_vol = r_const_vol;
        n_halt      = r_halt;
        n_pend_halt = r_pend_halt;
        n_decay     = r_decay;
        n_env_div   = r_env_div;
        n_env_start = r_env_start;
        n_sw_shift  = r_sw_shift;
        n_sw_negate = r_sw_negate;
        n_sw_period = r_sw_period;
        n_sw_enable = r_sw_enable;
        n_sw_div    = r_sw_div;
        n_sw_reload = r_sw_reload;
        n_length    = r_length;
        n_pend_len  = r_pend_len;
        n_len_snap  = r_len_snap;
        n_held      = r_held;
        sw_delta    = '0;
        wd          = i_item.write_data;

        if (i_item.operation == OP_WRITE) begin
            case (i_item.reg_index)
                REG_DUTY: begin
                    n_volume    = wd[3:0];
                    n_const_vol = wd[4];
                    n_pend_halt = wd[5];
                    n_duty_mode = wd[7:6];
                end
                REG_SWEEP: begin
                    n_sw_shift  = wd[2:0];
                    n_sw_negate = wd[3];
                    n_sw_period = wd[6:4];
                    n_sw_enable = wd[7];
                    n_sw_reload = 1'b1;
                end
                REG_LOW: begin
                    n_period = {r_period[10:8], wd};
                end
                REG_HIGH: begin
                    n_period    = {wd[2:0], r_period[7:0]};
                    n_pend_len  = f_length_load(wd[7:3]);
                    n_len_snap  = r_length;
                    n_duty_step = '0;
                    n_env_start = 1'b1;
                end
                REG_ENABLE: begin
                    if (!wd[0]) n_length = '0;
                end
                default: begin
                end
            endcase
            if (i_item.reg_index inside {[REG_DUTY:REG_ENABLE]}) begin
                n_held = (n_length != '0 && f_period_ok(n_period, n_sw_shift, n_sw_negate))
                       ? f_level(n_duty_mode, n_duty_step, n_const_vol ? n_volume : n_decay)
                       : 7'sd0;
            end
        end else begin
            // envelope on the quarter frame
            if (i_item.quarter_clock) begin
                if (n_env_start) begin
                    n_env_start = 1'b0;
                    n_decay     = 4'hF;
                    n_env_div   = n_volume;
                end else if (n_env_div == '0) begin
                    n_env_div = n_volume;
                    if (n_decay != '0) n_decay = n_decay - 4'd1;
                    else               n_decay = n_halt ? 4'hF : 4'h0;
                end else begin
                    n_env_div = n_env_div - 4'd1;
                end
                n_held = (n_length != '0 && f_period_ok(n_period, n_sw_shift, n_sw_negate))
                       ? f_level(n_duty_mode, n_duty_step, n_const_vol ? n_volume : n_decay)
                       : 7'sd0;
            end
            // sweep and length on the half frame
            if (i_item.half_clock) begin
                if (n_sw_div == '0) begin
                    n_sw_div = n_sw_period;
                    if (n_sw_enable && n_sw_shift != '0
                        && f_period_ok(n_period, n_sw_shift, n_sw_negate)) begin
                        sw_delta = n_period >> n_sw_shift;
                        n_period = n_sw_negate ? n_period + ~sw_delta : n_period + sw_delta;
                    end
                end else begin
                    n_sw_div = n_sw_div - 3'd1;
                end
                if (n_sw_reload) begin
                    n_sw_reload = 1'b0;
                    n_sw_div    = n_sw_period;
                end
                if (n_length != '0 && !n_halt) n_length = n_length - 8'd1;
                n_held = (n_length != '0 && f_period_ok(n_period, n_sw_shift, n_sw_negate))
                       ? f_level(n_duty_mode, n_duty_step, n_const_vol ? n_volume : n_decay)
                       : 7'sd0;
            end
            n_halt = n_pend_halt;
            // length load is dropped if the counter moved since the write
            if (n_pend_len != '0) begin
                if (n_length == n_len_snap) n_length = n_pend_len;
                n_pend_len = '0;
            end
            n_timer = n_timer - 12'd1;
            if (n_timer == '0) begin
                n_timer     = {n_period, 1'b0};
                n_duty_step = n_duty_step - 3'd1;
                if (n_length != '0 && f_period_ok(n_period, n_sw_shift, n_sw_negate)) begin
                    n_held = f_level(n_duty_mode, n_duty_step,
                                     n_const_vol ? n_volume : n_decay);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period    <= '0;
            r_timer     <= 12'd1;
            r_duty_step <= '0;
            r_duty_mode <= '0;
            r_volume    <= '0;
            r_const_vol <= 1'b0;
            r_halt      <= 1'b0;
            r_pend_halt <= 1'b0;
            r_decay     <= '0;
            r_env_div   <= 4'd1;
            r_env_start <= 1'b0;
            r_sw_shift  <= '0;
            r_sw_negate <= 1'b0;
            r_sw_period <= '0;
            r_sw_enable <= 1'b0;
            r_sw_div    <= 3'd1;
            r_sw_reload <= 1'b0;
            r_length    <= '0;
            r_pend_len  <= '0;
            r_len_snap  <= '0;
            r_held      <= '0;
        end else if (i_step) begin
            r_period    <= n_period;
            r_timer     <= n_timer;
            r_duty_step <= n_duty_step;
            r_duty_mode <= n_duty_mode;
            r_volume    <= n_volume;
            r_const_vol <= n_const_vol;
            r_halt      <= n_halt;
            r_pend_halt <= n_pend_halt;
            r_decay     <= n_decay;
            r_env_div   <= n_env_div;
            r_env_start <= n_env_start;
            r_sw_shift  <= n_sw_shift;
            r_sw_negate <= n_sw_negate;
            r_sw_period <= n_sw_period;
            r_sw_enable <= n_sw_enable;
            r_sw_div    <= n_sw_div;
            r_sw_reload <= n_sw_reload;
            r_length    <= n_length;
            r_pend_len  <= n_pend_len;
            r_len_snap  <= n_len_snap;
            r_held      <= n_held;
        end
    end

    assign o_result.sample_out     = n_held;
    assign o_result.length_nonzero = (n_length != '0);

endmodule

`default_nettype wire

// ===== rtl/pulse_wave_channel_unit.sv =====
`default_nettype none

// channel  direction  handshake                   payload
// in       input      i_in_valid / o_in_stall     i_operation i_reg_index i_write_data
//                                                 i_quarter_clock i_half_clock
// out      output     o_out_valid / i_out_stall   o_sample_out o_length_nonzero
//
// one beat per clock sustained while out stall is low; a beat's result is presented once it has
// passed the input register, then the channel update into the result register
// synchronous active-low reset puts the channel in its power-up state, both registers empty
// out stall holds the result; in stall rises only when both registers are full and held

module pulse_wave_channel_unit
    import pwc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic              i_operation,
    input  wire logic [2:0]        i_reg_index,
    input  wire logic [7:0]        i_write_data,
    input  wire logic              i_quarter_clock,
    input  wire logic              i_half_clock,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic signed [6:0]      o_sample_out,
    output logic                   o_length_nonzero
);

    logic    r_in_valid;
    t_item   r_in_item;
    logic    r_out_valid;
    t_result r_out_res;
    t_result core_res;
    logic    advance;

    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_in_item.operation     <= i_operation;
            r_in_item.reg_index     <= i_reg_index;
            r_in_item.write_data    <= i_write_data;
            r_in_item.quarter_clock <= i_quarter_clock;
            r_in_item.half_clock    <= i_half_clock;
        end
    end

    pwc_channel_state u_state (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_item   (r_in_item),
        .o_result (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) r_out_res <= core_res;
    end

    assign o_out_valid      = r_out_valid;
    assign o_sample_out     = r_out_res.sample_out;
    assign o_length_nonzero = r_out_res.length_nonzero;

endmodule

`default_nettype wire
